/* rtl/sa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_pkg
// Types, constants and helpers shared by the slab allocator files.
// ----------------------------------------------------------------------------
package sa_pkg;

	localparam int unsigned MAX_UNIT  = 2048;
	localparam int unsigned HDR_BYTES = 64;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef enum logic {
		REG_POOL_BASE       = 1'b0,
		REG_PAGES_AVAILABLE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] pool_base;
		logic [4:0]  pages_available;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  live;
		logic [15:0] age;
	} meta_t;

	// smallest class whose unit holds size (size in 1..2048)
	function automatic logic [2:0] size_class(input logic [11:0] size);
		logic [2:0] k;
		k = 3'd7;
		for (int i = 6; i >= 0; i--) begin
			if (size <= (12'd16 << i)) k = 3'(i);
		end
		return k;
	endfunction

	// slots per page for a class: (4096 - 64) / unit
	function automatic logic [7:0] slots_of(input logic [2:0] kind);
		logic [11:0] n;
		n = 12'd4032 >> ({1'b0, kind} + 4'd4);
		return n[7:0];
	endfunction

	function automatic logic [4:0] lowest_zero(input logic [31:0] w);
		logic [4:0] idx;
		idx = '0;
		for (int i = 31; i >= 0; i--) begin
			if (!w[i]) idx = 5'(i);
		end
		return idx;
	endfunction

endpackage

/* rtl/sa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/sa_apb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sa_apb_regs
// APB register file: pool base and claimable page count.
// ----------------------------------------------------------------------------
module sa_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output sa_pkg::cfg_t cfg
);

	logic [31:0] base_q;
	logic [4:0]  pa_q;
	sa_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign idx    = sa_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pa_q   <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				sa_pkg::REG_POOL_BASE:       base_q <= pwdata;
				sa_pkg::REG_PAGES_AVAILABLE: pa_q   <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sa_pkg::REG_POOL_BASE:       prdata = base_q;
			sa_pkg::REG_PAGES_AVAILABLE: prdata = {27'd0, pa_q};
		endcase
	end

	assign cfg.pool_base       = base_q;
	assign cfg.pages_available = pa_q;

endmodule

/* rtl/slab_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_allocator_unit
// Slab allocator with eight power-of-two size classes over a page pool.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and done
// pulses for one cycle with the result, which must be captured then. A free
// reads the page metadata and bitmap, then checks and writes them back; it
// ends without those reads when the page is outside the pool or unused. An
// allocate scans the page metadata RAM one page per cycle, then searches the
// page's slot bitmap one 32-bit word per cycle or, for a newly claimed page,
// skips it. An allocate that finds no page ends after the scan. A bad size,
// or a zero count of available pages, fails without a scan.
module slab_allocator_unit #(
	parameter int POOL_PAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [15:0] request_size,
	input  logic [31:0] address,
	output logic        done,
	output logic        ok,
	output logic [31:0] slot_address,
	output logic [11:0] freed_bytes,
	output logic        page_released
);

	localparam int PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
	localparam int MW = $bits(sa_pkg::meta_t);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_BMRD, S_BMSRCH, S_COMMIT, S_FRD, S_FCHK
	} state_t;

	sa_pkg::cfg_t  cfg;
	state_t        state_q;
	logic [POOL_PAGES-1:0] in_use_q;
	logic [15:0]   claim_cnt_q;
	logic [2:0]    kind_q;
	logic [PW-1:0] page_q, scan_idx_q, eval_idx_s1, pick_q, free_q;
	logic          eval_vld_s1, pick_vld_q, free_vld_q, claim_q;
	logic [11:0]   off_q;
	logic [15:0]   best_q;
	sa_pkg::meta_t best_meta_q;
	logic [2:0]    word_q;
	logic [7:0]    slot_q;
	logic          done_q, ok_q, rel_q;
	logic [31:0]   slot_addr_q;
	logic [11:0]   freed_q;

	logic          meta_we, bm_we;
	logic [PW-1:0] meta_raddr, bm_raddr, waddr;
	logic [MW-1:0] meta_rbits;
	sa_pkg::meta_t meta_rd, meta_wd;
	logic [255:0]  bm_rd, bm_wd;

	sa_apb_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	sa_ram #(.WIDTH(MW), .DEPTH(POOL_PAGES)) u_meta_ram (
		.clk(clk), .we(meta_we), .waddr(waddr), .wdata(meta_wd),
		.raddr(meta_raddr), .rdata(meta_rbits)
	);

	sa_ram #(.WIDTH(256), .DEPTH(POOL_PAGES)) u_bitmap_ram (
		.clk(clk), .we(bm_we), .waddr(waddr), .wdata(bm_wd),
		.raddr(bm_raddr), .rdata(bm_rd)
	);

	assign meta_rd = sa_pkg::meta_t'(meta_rbits);

	// accept-side decode
	logic        size_bad;
	logic [31:0] rel;
	logic        free_hit;
	logic [PW-1:0] rel_page;
	assign size_bad = (request_size == 16'd0) || (request_size > 16'(sa_pkg::MAX_UNIT))
		|| (cfg.pages_available == 5'd0);
	assign rel      = address - {cfg.pool_base[31:12], 12'd0};
	assign rel_page = rel[12 +: PW];
	assign free_hit = (rel[31:12] < 20'(POOL_PAGES)) && in_use_q[rel_page];

	// scan evaluation
	logic        cand, take, fr, last;
	logic [15:0] age_gap;
	assign age_gap = claim_cnt_q - meta_rd.age;
	assign cand = eval_vld_s1 && in_use_q[eval_idx_s1] && (meta_rd.kind == kind_q)
		&& (meta_rd.live < sa_pkg::slots_of(kind_q));
	assign take = cand && (!pick_vld_q || age_gap < best_q);
	assign fr   = eval_vld_s1 && !in_use_q[eval_idx_s1] && !free_vld_q
		&& (9'(eval_idx_s1) < 9'(cfg.pages_available));
	assign last = eval_vld_s1 && (eval_idx_s1 == PW'(POOL_PAGES - 1));

	// bitmap word search
	logic [31:0] bm_word;
	assign bm_word = bm_rd[32*word_q +: 32];

	// free check
	logic [11:0] unit, off_m, s_full;
	logic [7:0]  fs;
	logic        fgood;
	assign unit   = 12'd16 << meta_rd.kind;
	assign off_m  = off_q - 12'(sa_pkg::HDR_BYTES);
	assign s_full = off_m >> ({1'b0, meta_rd.kind} + 4'd4);
	assign fs     = s_full[7:0];
	assign fgood  = (off_q >= 12'(sa_pkg::HDR_BYTES)) && ((off_m & (unit - 12'd1)) == 12'd0)
		&& (s_full < {4'd0, sa_pkg::slots_of(meta_rd.kind)}) && bm_rd[fs]
		&& (meta_rd.live != 8'd0);

	assign meta_raddr = (state_q == S_FRD) ? page_q : scan_idx_q;
	assign bm_raddr   = (state_q == S_FRD || state_q == S_FCHK) ? page_q : pick_q;
	assign waddr      = (state_q == S_FCHK) ? page_q : pick_q;

	always_comb begin
		meta_we = 1'b0;
		bm_we   = 1'b0;
		meta_wd = best_meta_q;
		bm_wd   = bm_rd;
		unique case (state_q)
			S_COMMIT: begin
				meta_we = 1'b1;
				bm_we   = 1'b1;
				meta_wd = '{kind: kind_q, live: best_meta_q.live + 8'd1, age: best_meta_q.age};
				bm_wd   = (claim_q ? 256'd0 : bm_rd) | (256'd1 << slot_q);
			end
			S_FCHK: begin
				meta_we = fgood;
				bm_we   = fgood;
				meta_wd = '{kind: meta_rd.kind, live: meta_rd.live - 8'd1, age: meta_rd.age};
				bm_wd   = bm_rd & ~(256'd1 << fs);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_use_q    <= '0;
			claim_cnt_q <= '0;
			kind_q      <= '0;
			page_q      <= '0;
			scan_idx_q  <= '0;
			eval_idx_s1 <= '0;
			eval_vld_s1 <= 1'b0;
			pick_q      <= '0;
			pick_vld_q  <= 1'b0;
			free_q      <= '0;
			free_vld_q  <= 1'b0;
			claim_q     <= 1'b0;
			off_q       <= '0;
			best_q      <= '0;
			best_meta_q <= '0;
			word_q      <= '0;
			slot_q      <= '0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			rel_q       <= 1'b0;
			slot_addr_q <= '0;
			freed_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ok_q        <= 1'b0;
						rel_q       <= 1'b0;
						slot_addr_q <= '0;
						freed_q     <= '0;
						if (sa_pkg::func_t'(func) == sa_pkg::FUNC_ALLOC) begin
							kind_q      <= sa_pkg::size_class(request_size[11:0]);
							scan_idx_q  <= '0;
							eval_vld_s1 <= 1'b0;
							pick_vld_q  <= 1'b0;
							free_vld_q  <= 1'b0;
							if (size_bad) done_q <= 1'b1;
							else state_q <= S_SCAN;
						end else begin
							page_q <= rel_page;
							off_q  <= rel[11:0];
							if (free_hit) state_q <= S_FRD;
							else done_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					eval_vld_s1 <= 1'b1;
					eval_idx_s1 <= scan_idx_q;
					if (scan_idx_q != PW'(POOL_PAGES - 1)) scan_idx_q <= scan_idx_q + 1'b1;
					if (take) begin
						pick_vld_q  <= 1'b1;
						pick_q      <= eval_idx_s1;
						best_q      <= age_gap;
						best_meta_q <= meta_rd;
					end
					if (fr) begin
						free_vld_q <= 1'b1;
						free_q     <= eval_idx_s1;
					end
					if (last) begin
						if (pick_vld_q || take) begin
							claim_q <= 1'b0;
							state_q <= S_BMRD;
						end else if (free_vld_q || fr) begin
							pick_q      <= fr ? eval_idx_s1 : free_q;
							claim_q     <= 1'b1;
							best_meta_q <= '{kind: kind_q, live: 8'd0, age: claim_cnt_q};
							slot_q      <= '0;
							state_q     <= S_COMMIT;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_BMRD: begin
					word_q  <= '0;
					state_q <= S_BMSRCH;
				end
				S_BMSRCH: begin
					if (bm_word != 32'hFFFF_FFFF) begin
						slot_q  <= {word_q, sa_pkg::lowest_zero(bm_word)};
						state_q <= S_COMMIT;
					end else begin
						word_q <= word_q + 3'd1;
					end
				end
				S_COMMIT: begin
					in_use_q[pick_q] <= 1'b1;
					if (claim_q) claim_cnt_q <= claim_cnt_q + 16'd1;
					ok_q        <= 1'b1;
					slot_addr_q <= {cfg.pool_base[31:12] + 20'(pick_q),
						12'(sa_pkg::HDR_BYTES) + ({slot_q, 4'd0} << kind_q)};
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (fgood) begin
						ok_q    <= 1'b1;
						freed_q <= unit;
						if (meta_rd.live == 8'd1) begin
							in_use_q[page_q] <= 1'b0;
							rel_q            <= 1'b1;
						end
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign ok            = ok_q;
	assign slot_address  = slot_addr_q;
	assign freed_bytes   = freed_q;
	assign page_released = rel_q;

`ifndef SYNTHESIS
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !ok_q |-> slot_addr_q == 32'd0 && freed_q == 12'd0 && !rel_q)
		else $error("rejected transaction carries data");
	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rel_q |-> ok_q && freed_q != 12'd0)
		else $error("page released without a good free");
	a_claim_step: assert property (@(posedge clk) disable iff (!arst_n)
		claim_cnt_q != $past(claim_cnt_q) |-> done_q && ok_q && slot_addr_q != 32'd0
		|| done_q && ok_q)
		else $error("claim counter moved outside an allocation");
	a_accept_prog: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done_q)
		else $error("accepted transaction dropped");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for slab_allocator_unit: directed and random
// allocate/free transactions under several pool settings and idle mixes,
// checked against a behavioral allocator model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NPAGES = 16;
	localparam int WDOG_LIMIT = 2000;

	typedef struct packed {
		logic        ok;
		logic [31:0] slot_address;
		logic [11:0] freed_bytes;
		logic        page_released;
	} alloc_result_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        start, busy;
	logic        func;
	logic [15:0] request_size;
	logic [31:0] address;
	logic        done, ok, page_released;
	logic [31:0] slot_address;
	logic [11:0] freed_bytes;

	slab_allocator_unit #(.POOL_PAGES(NPAGES)) uut (.*);

	// allocator model state
	logic [31:0]  m_base;
	logic [4:0]   m_avail;
	logic         m_used [NPAGES];
	logic [2:0]   m_kind [NPAGES];
	int unsigned  m_live [NPAGES];
	logic [15:0]  m_age [NPAGES];
	logic [255:0] m_bits [NPAGES];
	logic [15:0]  m_claims;

	alloc_result_t expected_q[$];
	logic [31:0]   live_slots[$];
	int  errors = 0;
	int  idle_pct = 0;
	int  quiet_cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned slot_count(input int unsigned unit);
		return (4096 - 64) / unit;
	endfunction

	function automatic alloc_result_t model_alloc(input logic [15:0] size);
		alloc_result_t r;
		int unsigned unit, k, slots, lim;
		int pick;
		logic [15:0] best_gap, age_gap;
		r = '0;
		if (size == 0 || size > sa_pkg::MAX_UNIT || m_avail == 0) return r;
		unit = 16;
		k = 0;
		while (unit < size) begin
			unit = unit << 1;
			k++;
		end
		slots = slot_count(unit);
		pick = -1;
		best_gap = 0;
		for (int p = 0; p < NPAGES; p++) begin
			if (m_used[p] && m_kind[p] == k && m_live[p] < slots) begin
				age_gap = m_claims - m_age[p];
				if (pick < 0 || age_gap < best_gap) begin
					pick = p;
					best_gap = age_gap;
				end
			end
		end
		if (pick < 0) begin
			lim = (m_avail < NPAGES) ? m_avail : NPAGES;
			for (int p = 0; p < lim; p++)
				if (!m_used[p] && pick < 0) pick = p;
			if (pick < 0) return r;
			m_used[pick] = 1;
			m_kind[pick] = 3'(k);
			m_live[pick] = 0;
			m_bits[pick] = '0;
			m_age[pick] = m_claims;
			m_claims = m_claims + 16'd1;
		end
		for (int s = 0; s < slots; s++) begin
			if (!m_bits[pick][s]) begin
				m_bits[pick][s] = 1;
				m_live[pick]++;
				r.ok = 1;
				r.slot_address = (m_base & ~32'hFFF) + pick * 4096 + 64 + s * unit;
				return r;
			end
		end
		return r;
	endfunction

	function automatic alloc_result_t model_free(input logic [31:0] addr);
		alloc_result_t r;
		logic [31:0] rel;
		int unsigned p, off, unit, s;
		r = '0;
		rel = addr - (m_base & ~32'hFFF);
		p = rel >> 12;
		if (p >= NPAGES) return r;
		if (!m_used[p] || m_live[p] == 0) return r;
		off = rel & 32'hFFF;
		if (off < sa_pkg::HDR_BYTES) return r;
		off -= sa_pkg::HDR_BYTES;
		unit = 16 << m_kind[p];
		if (off % unit != 0 || off / unit >= slot_count(unit)) return r;
		s = off / unit;
		if (!m_bits[p][s]) return r;
		m_bits[p][s] = 0;
		m_live[p]--;
		if (m_live[p] == 0) begin
			m_used[p] = 0;
			r.page_released = 1;
		end
		r.ok = 1;
		r.freed_bytes = unit[11:0];
		return r;
	endfunction

	task automatic write_reg(input sa_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == sa_pkg::REG_POOL_BASE) m_base = val;
		else m_avail = val[4:0];
	endtask

	task automatic send_op(input sa_pkg::func_t f, input logic [15:0] size,
			input logic [31:0] addr);
		alloc_result_t r;
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		start <= 1;
		func <= f;
		request_size <= size;
		address <= addr;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 0;
		if (f == sa_pkg::FUNC_ALLOC) begin
			r = model_alloc(size);
			if (r.ok) live_slots.push_back(r.slot_address);
		end else begin
			r = model_free(addr);
		end
		expected_q.push_back(r);
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic free_some(input int n);
		int i;
		logic [31:0] a;
		repeat (n) begin
			if (live_slots.size() != 0) begin
				i = $urandom_range(live_slots.size() - 1);
				a = live_slots[i];
				live_slots.delete(i);
				send_op(sa_pkg::FUNC_FREE, 16'd0, a);
			end
		end
	endtask

	task automatic random_size(output logic [15:0] s);
		case ($urandom_range(9))
			0: s = 16'($urandom);
			1: s = 16'($urandom_range(16));
			default: s = 16'($urandom_range(1, 2048));
		endcase
	endtask

	task automatic test_directed();
		write_reg(sa_pkg::REG_POOL_BASE, 32'hFFFF_F123);
		write_reg(sa_pkg::REG_PAGES_AVAILABLE, 32'd0);
		send_op(sa_pkg::FUNC_ALLOC, 16'd16, 32'd0);
		drain();
		write_reg(sa_pkg::REG_PAGES_AVAILABLE, 32'd31);
		send_op(sa_pkg::FUNC_ALLOC, 16'd0, 32'd0);
		send_op(sa_pkg::FUNC_ALLOC, 16'd2049, 32'd0);
		send_op(sa_pkg::FUNC_ALLOC, 16'hFFFF, 32'd0);
		send_op(sa_pkg::FUNC_ALLOC, 16'd1, 32'd0);
		send_op(sa_pkg::FUNC_ALLOC, 16'd2048, 32'd0);
		send_op(sa_pkg::FUNC_ALLOC, 16'd17, 32'd0);
		send_op(sa_pkg::FUNC_ALLOC, 16'd2048, 32'd0);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'hFFFF_F000 + 32'd64 + 32'd2);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'hFFFF_F000 + 32'd8);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'hFFFF_F000 + 32'd64 + 32'd16 * 200);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'hFFFF_F000 + 32'd4095);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'h0001_0000 + 32'hFFFF_F040);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'hFFFF_EFFF);
		send_op(sa_pkg::FUNC_FREE, 16'hFFFF, 32'hFFFF_F040);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'hFFFF_F040);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'hFFFF_F040);
		drain();
		// base moved: old addresses now map elsewhere
		write_reg(sa_pkg::REG_POOL_BASE, 32'h0000_0000);
		free_some(2);
		send_op(sa_pkg::FUNC_FREE, 16'd0, 32'hFFFF_FFFF);
		drain();
		write_reg(sa_pkg::REG_POOL_BASE, 32'hFFFF_F123);
		live_slots.delete();
	endtask

	task automatic test_random(input int n, input logic [31:0] base, input int avail,
			input int pct);
		logic [15:0] s;
		idle_pct = pct;
		write_reg(sa_pkg::REG_POOL_BASE, base);
		write_reg(sa_pkg::REG_PAGES_AVAILABLE, avail);
		repeat (n) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					random_size(s);
					send_op(sa_pkg::FUNC_ALLOC, s, $urandom);
				end
				5, 6, 7: free_some(1);
				8: send_op(sa_pkg::FUNC_FREE, 16'($urandom),
					(base & ~32'hFFF) + $urandom_range(20 * 4096));
				default: send_op(sa_pkg::FUNC_FREE, 16'($urandom), $urandom);
			endcase
		end
		drain();
	endtask

	task automatic test_fill_drain();
		idle_pct = 0;
		write_reg(sa_pkg::REG_PAGES_AVAILABLE, 32'd2);
		repeat (6) send_op(sa_pkg::FUNC_ALLOC, 16'd1500, 32'd0);
		repeat (4) send_op(sa_pkg::FUNC_ALLOC, 16'd600, 32'd0);
		free_some(12);
		drain();
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result ok=%0d addr=%h", $time, ok, slot_address);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (ok !== exp_r.ok) begin
					$display("%0t: ok exp %0d got %0d", $time, exp_r.ok, ok);
					errors++;
				end
				if (slot_address !== exp_r.slot_address) begin
					$display("%0t: slot_address exp %h got %h", $time,
						exp_r.slot_address, slot_address);
					errors++;
				end
				if (freed_bytes !== exp_r.freed_bytes) begin
					$display("%0t: freed_bytes exp %0d got %0d", $time,
						exp_r.freed_bytes, freed_bytes);
					errors++;
				end
				if (page_released !== exp_r.page_released) begin
					$display("%0t: page_released exp %0d got %0d", $time,
						exp_r.page_released, page_released);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		start = 0;
		func = 0;
		request_size = '0;
		address = '0;
		m_base = '0;
		m_avail = '0;
		m_claims = '0;
		for (int p = 0; p < NPAGES; p++) begin
			m_used[p] = 0;
			m_kind[p] = 0;
			m_live[p] = 0;
			m_age[p] = 0;
			m_bits[p] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;
		test_directed();
		test_random(240, 32'h8000_0000, 16, 0);
		test_random(240, 32'hFFFF_C7AB, 3, 51);
		test_fill_drain();
		test_random(220, 32'h1234_5FFF, 31, 16);
		test_random(200, 32'h0000_0000, 1, 0);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
